FILE: src/double_sign_guard_log_writer_defines.svh
// Assertion macros shared by the double-sign guard RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef DOUBLE_SIGN_GUARD_LOG_WRITER_DEFINES_SVH
`define DOUBLE_SIGN_GUARD_LOG_WRITER_DEFINES_SVH

// same-cycle implication, off during reset
`define DSGLW_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define DSGLW_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dsglw_pkg.sv
// Types, codes and constants of the double-sign guard log writer.
// Depends on nothing; used by dsglw_fnv and the top level.
`default_nettype none

package dsglw_pkg;

    // request codes
    localparam logic [1:0] REQ_ADVANCE  = 2'd0;
    localparam logic [1:0] REQ_READ     = 2'd1;
    localparam logic [1:0] REQ_WIPE     = 2'd2;
    localparam logic [1:0] REQ_WIPE_ALL = 2'd3;

    // status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_BAD_SLOT = 2'd1;
    localparam logic [1:0] STS_UNKNOWN  = 2'd2;
    localparam logic [1:0] STS_STALE    = 2'd3;

    // erase kinds
    localparam logic [1:0] ERASE_NONE   = 2'd0;
    localparam logic [1:0] ERASE_SECTOR = 2'd1;
    localparam logic [1:0] ERASE_REGION = 2'd2;
    localparam logic [1:0] ERASE_STORE  = 2'd3;

    // raw message types
    localparam logic [7:0] MT_PROPOSAL  = 8'h20;
    localparam logic [7:0] MT_PREVOTE   = 8'h01;
    localparam logic [7:0] MT_PRECOMMIT = 8'h02;

    localparam logic [31:0] REC_MAGIC = 32'hA1A2A3C0;
    localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;
    localparam int          HDR_BYTES = 40;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EVAL,
        ST_HASH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic start;   // load header, seed with basis
        logic clear;   // no record: checksum reads zero
    } hash_ctl_t;

    typedef struct packed {
        logic busy;
        logic last;    // final byte goes in this cycle
    } hash_sts_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         erase_kind;
        logic [7:0]         erase_sec;
        logic [7:0]         write_sector;
        logic [5:0]         write_rec;
        logic [63:0]        write_seq;
        logic               mark_valid;
        logic signed [63:0] mark_height;
        logic signed [31:0] mark_round;
        logic [7:0]         mark_type;
    } res_t;

    // message type to step; zero for an unknown type
    function automatic logic [1:0] step_of(input logic [7:0] mt);
        logic [1:0] s;
        case (mt)
            MT_PROPOSAL:  s = 2'd1;
            MT_PREVOTE:   s = 2'd2;
            MT_PRECOMMIT: s = 2'd3;
            default:      s = 2'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: src/dsglw_fnv.sv
// Byte-serial FNV-1a 32 engine over the 40-byte record header.
// Depends on dsglw_pkg.
`default_nettype none

module dsglw_fnv
    import dsglw_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire hash_ctl_t        ctl,
    input  wire logic [8*HDR_BYTES-1:0] header,
    output hash_sts_t             sts,
    output logic [31:0]           checksum
);

    logic                    busy_reg;
    logic [5:0]              cnt_reg;
    logic [8*HDR_BYTES-1:0]  hdr_reg;
    logic [31:0]             x_reg;
    logic [31:0]             mixed;
    logic [31:0]             prod;

    assign mixed = x_reg ^ {24'd0, hdr_reg[7:0]};
    assign prod  = mixed * FNV_PRIME;

    assign sts.busy = busy_reg;
    assign sts.last = busy_reg && (cnt_reg == 6'(HDR_BYTES - 1));
    assign checksum = x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (sts.last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            x_reg   <= FNV_BASIS;
            hdr_reg <= header;
        end
        else if (ctl.clear)
        begin
            x_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg   <= prod;
            hdr_reg <= {8'd0, hdr_reg[8*HDR_BYTES-1:8]};
        end
    end

endmodule

`default_nettype wire

FILE: src/double_sign_guard_log_writer.sv
// Double-sign guard with rolling-log record placement, top level.
// Depends on dsglw_pkg, dsglw_fnv and double_sign_guard_log_writer_defines.svh.
//
// Use: one request beat in (in_valid/in_stall), one result beat out
// (out_valid/out_stall). in_stall is high from acceptance until the
// sequencer has finished the request; one request is in work at a time.
// Sequence: an advance that writes a record goes from accept to out_valid
// through a memory read, an evaluate step, then the byte-serial FNV
// unit (one header byte per cycle, one 32x32 multiply), then the result
// load. Read, wipe and rejected requests skip the FNV unit.
// The result sits in an output register; the next request is taken while
// it waits, and only the final load waits for the receiver to take it.
// Per-slot state lives in a one-port memory; a live bit per slot marks
// entries written since reset or wipe, so reset and wipe-all take effect
// at once, with no clearing pass. A stale entry reads as the reset mark.
`default_nettype none
`include "double_sign_guard_log_writer_defines.svh"

module double_sign_guard_log_writer
    import dsglw_pkg::*;
#(
    parameter int SLOT_COUNT         = 16,
    parameter int SECTORS_PER_SLOT   = 16,
    parameter int RECORDS_PER_SECTOR = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         req_type,
    input  wire logic [7:0]         slot_index,
    input  wire logic [7:0]         msg_type,
    input  wire logic signed [63:0] block_height,
    input  wire logic signed [31:0] round_number,
    input  wire logic [63:0]        chain_hash,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [1:0]              erase_kind,
    output logic [7:0]              erase_sec,
    output logic [7:0]              write_sector,
    output logic [5:0]              write_rec,
    output logic [63:0]             write_seq,
    output logic [31:0]             record_checksum,
    output logic                    mark_valid,
    output logic signed [63:0]      mark_height,
    output logic signed [31:0]      mark_round,
    output logic [7:0]              mark_type
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SEC_W  = $clog2(SECTORS_PER_SLOT);
    localparam int REC_W  = $clog2(RECORDS_PER_SECTOR + 1);

    typedef struct packed {
        logic               valid;
        logic signed [63:0] height;
        logic signed [31:0] round;
        logic [7:0]         mtype;
        logic [SEC_W-1:0]   sector;
        logic [REC_W-1:0]   rec_ptr;
        logic [63:0]        seq_ptr;
        logic [63:0]        chain;
    } ent_t;

    localparam ent_t ENT_RESET = '{valid: 1'b0, height: '0, round: '0, mtype: '0,
                                   sector: '0, rec_ptr: '0, seq_ptr: 64'd1,
                                   chain: '0};

    // sequencer
    state_t state_reg, state_next;
    logic   in_acc, out_free, ld_in, do_eval, ld_out;

    // captured request beat
    logic [1:0]         req_reg;
    logic [7:0]         slot_reg;
    logic [7:0]         msg_reg;
    logic signed [63:0] height_reg;
    logic signed [31:0] round_reg;
    logic [63:0]        hash_reg;

    // slot store
    ent_t                  mem [SLOT_COUNT];
    ent_t                  rd_reg;
    logic [SLOT_COUNT-1:0] live_reg;
    logic [SLOT_W-1:0]     slot_a;

    // evaluation
    ent_t               cur, new_ent;
    logic               slot_ok, adv, full, do_write, mem_we;
    logic [1:0]         step_new, step_cur;
    logic [SEC_W-1:0]   sec_new;
    logic [REC_W-1:0]   rec_idx;
    logic [15:0]        region_base, abs_sec;
    logic [REC_W+5:0]   rec_wide;
    logic [8*HDR_BYTES-1:0] header;
    res_t               res, pend_reg, out_reg;
    logic               out_valid_reg;
    logic [31:0]        sum_out_reg;

    // checksum unit
    hash_ctl_t   hash_ctl;
    hash_sts_t   hash_sts;
    logic [31:0] checksum;

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign slot_a   = slot_reg[SLOT_W-1:0];

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_LOOK;
            ST_LOOK:   state_next = ST_EVAL;
            ST_EVAL:   state_next = do_write ? ST_HASH : ST_FINISH;
            ST_HASH:   if (hash_sts.last) state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb
    begin
        in_stall = 1'b1;
        ld_in    = 1'b0;
        do_eval  = 1'b0;
        ld_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                ld_in    = in_valid;
            end
            ST_EVAL:   do_eval = 1'b1;
            ST_FINISH: ld_out  = out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_in)
        begin
            req_reg    <= req_type;
            slot_reg   <= slot_index;
            msg_reg    <= msg_type;
            height_reg <= block_height;
            round_reg  <= round_number;
            hash_reg   <= chain_hash;
        end
    end

    // ---------------- evaluate ----------------
    always_comb
    begin
        cur      = live_reg[slot_a] ? rd_reg : ENT_RESET;
        slot_ok  = {1'b0, slot_reg} < 9'(SLOT_COUNT);
        step_new = step_of(msg_reg);
        step_cur = step_of(cur.mtype);

        // strictly greater on (height, round, step), signed compares
        adv = !cur.valid
           || (height_reg > cur.height)
           || ((height_reg == cur.height)
               && ((round_reg > cur.round)
                   || ((round_reg == cur.round) && (step_new > step_cur))));

        full = cur.rec_ptr >= REC_W'(RECORDS_PER_SECTOR);
        if (!full)
            sec_new = cur.sector;
        else if (cur.sector == SEC_W'(SECTORS_PER_SLOT - 1))
            sec_new = '0;
        else
            sec_new = cur.sector + SEC_W'(1);
        rec_idx = full ? '0 : cur.rec_ptr;

        region_base = 16'(slot_reg) * 16'(SECTORS_PER_SLOT);
        abs_sec     = region_base + 16'(sec_new);
        rec_wide    = {6'd0, rec_idx};

        new_ent.valid   = 1'b1;
        new_ent.height  = height_reg;
        new_ent.round   = round_reg;
        new_ent.mtype   = msg_reg;
        new_ent.sector  = sec_new;
        new_ent.rec_ptr = rec_idx + REC_W'(1);
        new_ent.seq_ptr = cur.seq_ptr + 64'd1;
        new_ent.chain   = hash_reg;

        // header bytes, byte 0 in the low bits
        header = {24'd0, msg_reg, round_reg, height_reg, hash_reg,
                  cur.seq_ptr, 32'd0, REC_MAGIC};

        res      = '0;
        do_write = 1'b0;
        if (req_reg == REQ_WIPE_ALL)
        begin
            res.erase_kind = ERASE_STORE;
        end
        else if (!slot_ok)
        begin
            res.status = STS_BAD_SLOT;
        end
        else
        begin
            unique case (req_reg)
                REQ_WIPE:
                begin
                    res.erase_kind = ERASE_REGION;
                    res.erase_sec  = region_base[7:0];
                end
                REQ_READ:
                begin
                    res.mark_valid  = cur.valid;
                    res.mark_height = cur.height;
                    res.mark_round  = cur.round;
                    res.mark_type   = cur.mtype;
                end
                default:
                begin
                    res.mark_valid  = cur.valid;
                    res.mark_height = cur.height;
                    res.mark_round  = cur.round;
                    res.mark_type   = cur.mtype;
                    if (step_new == 2'd0)
                    begin
                        res.status = STS_UNKNOWN;
                    end
                    else if (!adv)
                    begin
                        res.status = STS_STALE;
                    end
                    else
                    begin
                        do_write         = 1'b1;
                        res.write_sector = abs_sec[7:0];
                        res.write_rec    = rec_wide[5:0];
                        res.write_seq    = cur.seq_ptr;
                        res.mark_valid   = 1'b1;
                        res.mark_height  = height_reg;
                        res.mark_round   = round_reg;
                        res.mark_type    = msg_reg;
                        if (full)
                        begin
                            res.erase_kind = ERASE_SECTOR;
                            res.erase_sec  = abs_sec[7:0];
                        end
                    end
                end
            endcase
        end
    end

    assign mem_we         = do_eval && do_write;
    assign hash_ctl.start = mem_we;
    assign hash_ctl.clear = do_eval && !do_write;

    // ---------------- slot store ----------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOOK)
        begin
            rd_reg <= mem[slot_a];
        end
        if (mem_we)
        begin
            mem[slot_a] <= new_ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
        end
        else if (do_eval)
        begin
            if (req_reg == REQ_WIPE_ALL)
                live_reg <= '0;
            else if (slot_ok && (req_reg == REQ_WIPE))
                live_reg[slot_a] <= 1'b0;
            else if (do_write)
                live_reg[slot_a] <= 1'b1;
        end
    end

    dsglw_fnv u_fnv (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (hash_ctl),
        .header   (header),
        .sts      (hash_sts),
        .checksum (checksum)
    );

    // ---------------- result register ----------------
    always_ff @(posedge clk)
    begin
        if (do_eval)
        begin
            pend_reg <= res;
        end
        if (ld_out)
        begin
            out_reg     <= pend_reg;
            sum_out_reg <= checksum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ld_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_reg.status;
    assign erase_kind      = out_reg.erase_kind;
    assign erase_sec       = out_reg.erase_sec;
    assign write_sector    = out_reg.write_sector;
    assign write_rec       = out_reg.write_rec;
    assign write_seq       = out_reg.write_seq;
    assign record_checksum = sum_out_reg;
    assign mark_valid      = out_reg.mark_valid;
    assign mark_height     = out_reg.mark_height;
    assign mark_round      = out_reg.mark_round;
    assign mark_type       = out_reg.mark_type;

    // ---------------- checks ----------------
    `DSGLW_ASSERT_NXT(a_accept_look, in_acc, state_reg == ST_LOOK, "accepted beat not looked up")
    `DSGLW_ASSERT_NXT(a_finish_hold, (state_reg == ST_FINISH) && out_valid_reg && out_stall, state_reg == ST_FINISH, "result loaded over a waiting beat")
    `DSGLW_ASSERT_NXT(a_finish_load, (state_reg == ST_FINISH) && !(out_valid_reg && out_stall), out_valid_reg, "finished result not presented")
    `DSGLW_ASSERT_IMP(a_last_in_hash, hash_sts.last, state_reg == ST_HASH, "checksum finished outside hash phase")
    `DSGLW_ASSERT_NXT(a_write_hash, mem_we, hash_sts.busy, "record written without checksum run")

endmodule

`default_nettype wire
